[rtl/assert_macros.svh]
// Assertion macros used by the tokenizer unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CTT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("config_text_tokenizer: implication check failed");
`define CTT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("config_text_tokenizer: next-cycle check failed");
`else
`define CTT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CTT_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[rtl/ctt_pkg.sv]
// Types, constants and character classes for the configuration text tokenizer.
`default_nettype none
package ctt_pkg;

  localparam int LINE_BITS_DEF = 16;
  localparam int LINE_OUT_W    = 16;
  localparam int MAX_RES       = 3;
  localparam int Q_DEPTH       = 4;
  localparam int PTR_W         = $clog2(Q_DEPTH);
  localparam int LVL_W         = $clog2(Q_DEPTH + 1);

  typedef enum logic [9:0] {
    M_IDLE       = 10'b0000000001,
    M_LBRACE     = 10'b0000000010,
    M_SLASH      = 10'b0000000100,
    M_COMMENT    = 10'b0000001000,
    M_STRING     = 10'b0000010000,
    M_STR_RBRACE = 10'b0000100000,
    M_NUMBER     = 10'b0001000000,
    M_NUM_DOT    = 10'b0010000000,
    M_IDENT      = 10'b0100000000,
    M_ERROR      = 10'b1000000000
  } mode_t;

  typedef enum logic [1:0] {
    CL_DQUOTE = 2'd0,
    CL_SQUOTE = 2'd1,
    CL_DBRACE = 2'd2
  } closer_t;

  typedef enum logic [1:0] {
    K_TEXT = 2'd0,
    K_DONE = 2'd1,
    K_ERR  = 2'd2,
    K_END  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    TT_OPEN   = 3'd0,
    TT_CLOSE  = 3'd1,
    TT_COLON  = 3'd2,
    TT_COMMA  = 3'd3,
    TT_SEMI   = 3'd4,
    TT_STRING = 3'd5,
    TT_NUMBER = 3'd6,
    TT_IDENT  = 3'd7
  } tok_t;

  // Error and end events carry a zero token type.
  localparam tok_t TT_NULL = TT_OPEN;

  localparam logic E_BADCHAR = 1'b0;
  localparam logic E_UNTERM  = 1'b1;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UZ     = 8'h5A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LZ     = 8'h7A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef struct packed {
    kind_t      kind;
    tok_t       tok;
    logic [7:0] text;
    logic       err;
  } ev_t;

  typedef struct packed {
    ev_t                   ev;
    logic [LINE_OUT_W-1:0] line;
    logic                  last;
  } res_t;

  typedef struct packed {
    mode_t   mode;
    closer_t closer;
    logic    esc;
  } state_t;

  typedef struct packed {
    mode_t             mode;
    closer_t           closer;
    logic              esc;
    logic              bump;
    logic              clear;
    logic [1:0]        n;
    ev_t [MAX_RES-1:0] ev;
  } step_t;

  typedef struct packed {
    logic [1:0]         n;
    res_t [MAX_RES-1:0] rec;
  } push_t;

  function automatic ev_t mk_ev(kind_t k, tok_t t, logic [7:0] b, logic e);
    ev_t r;
    r.kind = k;
    r.tok  = t;
    r.text = b;
    r.err  = e;
    return r;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ));
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_ident_tail(logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == CH_MINUS) || (c == CH_DOLLAR) ||
           (c == CH_UNDER);
  endfunction

endpackage
`default_nettype wire

[rtl/config_text_tokenizer_unit.sv]
// Streaming tokenizer for configuration text: bytes in, token events out.
//
// Input channel: in_valid / in_stall with in_action (0 byte, 1 end of source)
// and in_char_byte. One item is taken per cycle while the block keeps up.
// Output channel: out_valid / out_stall, one event at a time, carrying kind,
// token type, text byte, error code, line number and last_of_run, which marks
// the final event that one input item causes.
// Path: an accepted item is registered, then scanned from that register once
// all its events fit in the queue; its first event is offered from the queue
// head once the events have been written into the queue.
// Throughput: one input item per cycle while items give at most one event each
// and out_stall is low; items giving two or three events fill the four-entry
// event queue faster than it drains, as it hands out one entry per cycle.
// in_stall rises when the registered item's events do not fit in the queue:
// while out_stall holds events back, or when items giving several events come
// faster than the queue drains. A stalled event holds.
// Reset (rst_n low, synchronous) empties the queue, returns the scanner to
// idle between tokens and sets the line counter to one. The end marker does
// the same to the scanner and line counter once its events are queued.
`default_nettype none
`include "assert_macros.svh"
module config_text_tokenizer_unit #(
  parameter int LINE_BITS = ctt_pkg::LINE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_action,
  input  logic [7:0] in_char_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_event_kind,
  output logic [2:0] out_token_type,
  output logic [7:0] out_text_byte,
  output logic       out_error_code,
  output logic [15:0] out_line_number,
  output logic       out_last_of_run
);
  import ctt_pkg::*;

  localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);
  localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};

  logic                 in_v_r, in_v_nxt;
  logic                 in_action_r;
  logic [7:0]           in_char_r;
  mode_t                mode_r;
  closer_t              closer_r;
  logic                 esc_r;
  logic [LINE_BITS-1:0] line_r, line_nxt;
  logic [LINE_OUT_W-1:0] line16;

  state_t               st;
  step_t                step_o;
  push_t                push;
  res_t                 head;
  logic [LVL_W-1:0]     q_level;
  logic                 pop;
  logic                 proc_go;
  logic                 in_take;

  generate
    if (LINE_BITS >= LINE_OUT_W) begin : g_line_cut
      assign line16 = line_r[LINE_OUT_W-1:0];
    end else begin : g_line_ext
      assign line16 = {{(LINE_OUT_W-LINE_BITS){1'b0}}, line_r};
    end
  endgenerate

  assign st.mode   = mode_r;
  assign st.closer = closer_r;
  assign st.esc    = esc_r;

  ctt_step u_step (
    .st        (st),
    .action    (in_action_r),
    .char_byte (in_char_r),
    .res       (step_o)
  );

  assign pop     = out_valid && !out_stall;
  // Scan the held item only if all its events fit after this cycle's pop.
  assign proc_go = in_v_r &&
                   (({1'b0, q_level} + (LVL_W+1)'(step_o.n) - (LVL_W+1)'(pop)) <=
                    (LVL_W+1)'(Q_DEPTH));
  assign in_stall = in_v_r && !proc_go;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    push.n = proc_go ? step_o.n : 2'd0;
    for (int i = 0; i < MAX_RES; i++) begin
      push.rec[i].ev   = step_o.ev[i];
      push.rec[i].line = line16;
      push.rec[i].last = (2'(i + 1) == step_o.n);
    end
  end

  ctt_outq u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .level (q_level)
  );

  always_comb begin
    in_v_nxt = in_take ? 1'b1 : (proc_go ? 1'b0 : in_v_r);
    line_nxt = line_r;
    if (step_o.clear) begin
      line_nxt = LINE_ONE;
    end else if (step_o.bump && (line_r != LINE_MAX)) begin
      line_nxt = line_r + LINE_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_action_r <= in_action;
      in_char_r   <= in_char_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r   <= 1'b0;
      mode_r   <= M_IDLE;
      closer_r <= CL_DQUOTE;
      esc_r    <= 1'b0;
      line_r   <= LINE_ONE;
    end else begin
      in_v_r <= in_v_nxt;
      if (proc_go) begin
        mode_r   <= step_o.mode;
        closer_r <= step_o.closer;
        esc_r    <= step_o.esc;
        line_r   <= line_nxt;
      end
    end
  end

  assign out_valid       = (q_level != '0);
  assign out_event_kind  = head.ev.kind;
  assign out_token_type  = head.ev.tok;
  assign out_text_byte   = head.ev.text;
  assign out_error_code  = head.ev.err;
  assign out_line_number = head.line;
  assign out_last_of_run = head.last;

  `CTT_ASSERT_IMP(a_line_nonzero, clk, rst_n, out_valid, out_line_number != '0)
  `CTT_ASSERT_NXT(a_end_resets, clk, rst_n, proc_go && in_action_r, (mode_r == M_IDLE) && (line_r == LINE_ONE))
  `CTT_ASSERT_IMP(a_error_silent, clk, rst_n, proc_go && !in_action_r && (mode_r == M_ERROR), step_o.n == 2'd0)
  `CTT_ASSERT_IMP(a_queue_bound, clk, rst_n, 1'b1, q_level <= LVL_W'(Q_DEPTH))

endmodule
`default_nettype wire

[rtl/ctt_step.sv]
// Scanner step: next scan state and up to three events for one source item.
`default_nettype none
module ctt_step (
  input  ctt_pkg::state_t st,
  input  logic            action,
  input  logic [7:0]      char_byte,
  output ctt_pkg::step_t  res
);
  import ctt_pkg::*;

  typedef struct packed {
    mode_t   mode;
    logic    set_str;
    closer_t closer;
    logic    bump;
    logic    ev_v;
    ev_t     ev;
  } idle_t;

  typedef struct packed {
    mode_t mode;
    logic  esc;
    logic  bump;
    logic  ev_v;
    ev_t   ev;
  } str_t;

  // Byte seen between tokens.
  function automatic idle_t idle_char(logic [7:0] c);
    idle_t r;
    r = '0;
    r.mode = M_IDLE;
    r.closer = CL_DQUOTE;
    r.ev = mk_ev(K_TEXT, TT_NULL, CH_NUL, E_BADCHAR);
    if (is_space(c)) begin
      r.bump = (c == CH_LF);
    end else begin
      case (c)
        CH_HASH:   r.mode = M_COMMENT;
        CH_SLASH:  r.mode = M_SLASH;
        CH_LBRACE: r.mode = M_LBRACE;
        CH_RBRACE: begin
          r.ev_v = 1'b1;
          r.ev = mk_ev(K_DONE, TT_CLOSE, CH_NUL, E_BADCHAR);
        end
        CH_COLON: begin
          r.ev_v = 1'b1;
          r.ev = mk_ev(K_DONE, TT_COLON, CH_NUL, E_BADCHAR);
        end
        CH_COMMA: begin
          r.ev_v = 1'b1;
          r.ev = mk_ev(K_DONE, TT_COMMA, CH_NUL, E_BADCHAR);
        end
        CH_SEMI: begin
          r.ev_v = 1'b1;
          r.ev = mk_ev(K_DONE, TT_SEMI, CH_NUL, E_BADCHAR);
        end
        CH_DQUOTE: begin
          r.mode = M_STRING;
          r.set_str = 1'b1;
          r.closer = CL_DQUOTE;
        end
        CH_SQUOTE: begin
          r.mode = M_STRING;
          r.set_str = 1'b1;
          r.closer = CL_SQUOTE;
        end
        default: begin
          r.ev_v = 1'b1;
          if (is_digit(c)) begin
            r.mode = M_NUMBER;
            r.ev = mk_ev(K_TEXT, TT_NUMBER, c, E_BADCHAR);
          end else if (is_alpha(c)) begin
            r.mode = M_IDENT;
            r.ev = mk_ev(K_TEXT, TT_IDENT, c, E_BADCHAR);
          end else begin
            r.mode = M_ERROR;
            r.ev = mk_ev(K_ERR, TT_NULL, CH_NUL, E_BADCHAR);
          end
        end
      endcase
    end
    return r;
  endfunction

  // Byte seen inside a string body.
  function automatic str_t string_char(closer_t cl, logic esc, logic [7:0] c);
    str_t r;
    r = '0;
    r.mode = M_STRING;
    r.ev = mk_ev(K_TEXT, TT_STRING, c, E_BADCHAR);
    if (esc) begin
      r.ev_v = 1'b1;
      r.bump = (c == CH_LF);
    end else if (((cl == CL_DQUOTE) && (c == CH_DQUOTE)) ||
                 ((cl == CL_SQUOTE) && (c == CH_SQUOTE))) begin
      r.mode = M_IDLE;
      r.ev_v = 1'b1;
      r.ev = mk_ev(K_DONE, TT_STRING, CH_NUL, E_BADCHAR);
    end else if ((cl == CL_DBRACE) && (c == CH_RBRACE)) begin
      r.mode = M_STR_RBRACE;
    end else if (c == CH_BSLASH) begin
      r.esc = 1'b1;
    end else begin
      r.ev_v = 1'b1;
      r.bump = (c == CH_LF);
    end
    return r;
  endfunction

  idle_t ic;
  str_t  sc;

  assign ic = idle_char(char_byte);
  assign sc = string_char(st.closer, st.esc, char_byte);

  always_comb begin
    res.mode   = st.mode;
    res.closer = st.closer;
    res.esc    = st.esc;
    res.bump   = 1'b0;
    res.clear  = 1'b0;
    res.n      = 2'd0;
    for (int i = 0; i < MAX_RES; i++) begin
      res.ev[i] = mk_ev(K_TEXT, TT_NULL, CH_NUL, E_BADCHAR);
    end

    if (action) begin
      // End of source: flush what is pending, then the end event, then reset.
      res.clear  = 1'b1;
      res.mode   = M_IDLE;
      res.closer = CL_DQUOTE;
      res.esc    = 1'b0;
      case (st.mode)
        M_LBRACE: begin
          res.ev[0] = mk_ev(K_DONE, TT_OPEN, CH_NUL, E_BADCHAR);
          res.ev[1] = mk_ev(K_END, TT_NULL, CH_NUL, E_BADCHAR);
          res.n = 2'd2;
        end
        M_SLASH: begin
          res.ev[0] = mk_ev(K_ERR, TT_NULL, CH_NUL, E_BADCHAR);
          res.ev[1] = mk_ev(K_END, TT_NULL, CH_NUL, E_BADCHAR);
          res.n = 2'd2;
        end
        M_STRING, M_STR_RBRACE: begin
          res.ev[0] = mk_ev(K_ERR, TT_NULL, CH_NUL, E_UNTERM);
          res.ev[1] = mk_ev(K_END, TT_NULL, CH_NUL, E_BADCHAR);
          res.n = 2'd2;
        end
        M_NUMBER: begin
          res.ev[0] = mk_ev(K_DONE, TT_NUMBER, CH_NUL, E_BADCHAR);
          res.ev[1] = mk_ev(K_END, TT_NULL, CH_NUL, E_BADCHAR);
          res.n = 2'd2;
        end
        M_NUM_DOT: begin
          res.ev[0] = mk_ev(K_DONE, TT_NUMBER, CH_NUL, E_BADCHAR);
          res.ev[1] = mk_ev(K_ERR, TT_NULL, CH_NUL, E_BADCHAR);
          res.ev[2] = mk_ev(K_END, TT_NULL, CH_NUL, E_BADCHAR);
          res.n = 2'd3;
        end
        M_IDENT: begin
          res.ev[0] = mk_ev(K_DONE, TT_IDENT, CH_NUL, E_BADCHAR);
          res.ev[1] = mk_ev(K_END, TT_NULL, CH_NUL, E_BADCHAR);
          res.n = 2'd2;
        end
        default: begin
          res.ev[0] = mk_ev(K_END, TT_NULL, CH_NUL, E_BADCHAR);
          res.n = 2'd1;
        end
      endcase
    end else begin
      case (st.mode)
        M_LBRACE: begin
          if (char_byte == CH_LBRACE) begin
            res.mode   = M_STRING;
            res.closer = CL_DBRACE;
            res.esc    = 1'b0;
          end else begin
            res.ev[0] = mk_ev(K_DONE, TT_OPEN, CH_NUL, E_BADCHAR);
            res.ev[1] = ic.ev;
            res.n     = 2'd1 + {1'b0, ic.ev_v};
            res.mode  = ic.mode;
            res.bump  = ic.bump;
            if (ic.set_str) begin
              res.closer = ic.closer;
              res.esc    = 1'b0;
            end
          end
        end
        M_SLASH: begin
          if (char_byte == CH_SLASH) begin
            res.mode = M_COMMENT;
          end else begin
            res.ev[0] = mk_ev(K_ERR, TT_NULL, CH_NUL, E_BADCHAR);
            res.n     = 2'd1;
            res.mode  = M_ERROR;
          end
        end
        M_COMMENT: begin
          if (char_byte == CH_LF) begin
            res.bump = 1'b1;
            res.mode = M_IDLE;
          end
        end
        M_STRING: begin
          res.mode  = sc.mode;
          res.esc   = sc.esc;
          res.bump  = sc.bump;
          res.ev[0] = sc.ev;
          res.n     = {1'b0, sc.ev_v};
        end
        M_STR_RBRACE: begin
          if (char_byte == CH_RBRACE) begin
            res.ev[0] = mk_ev(K_DONE, TT_STRING, CH_NUL, E_BADCHAR);
            res.n     = 2'd1;
            res.mode  = M_IDLE;
          end else begin
            // Lone brace was text: emit it, then treat this byte as string body.
            res.ev[0] = mk_ev(K_TEXT, TT_STRING, CH_RBRACE, E_BADCHAR);
            res.ev[1] = sc.ev;
            res.n     = 2'd1 + {1'b0, sc.ev_v};
            res.mode  = sc.mode;
            res.esc   = sc.esc;
            res.bump  = sc.bump;
          end
        end
        M_NUMBER: begin
          if (is_digit(char_byte)) begin
            res.ev[0] = mk_ev(K_TEXT, TT_NUMBER, char_byte, E_BADCHAR);
            res.n     = 2'd1;
          end else if (char_byte == CH_DOT) begin
            res.mode = M_NUM_DOT;
          end else begin
            res.ev[0] = mk_ev(K_DONE, TT_NUMBER, CH_NUL, E_BADCHAR);
            res.ev[1] = ic.ev;
            res.n     = 2'd1 + {1'b0, ic.ev_v};
            res.mode  = ic.mode;
            res.bump  = ic.bump;
            if (ic.set_str) begin
              res.closer = ic.closer;
              res.esc    = 1'b0;
            end
          end
        end
        M_NUM_DOT: begin
          if (is_digit(char_byte)) begin
            res.ev[0] = mk_ev(K_TEXT, TT_NUMBER, CH_DOT, E_BADCHAR);
            res.ev[1] = mk_ev(K_TEXT, TT_NUMBER, char_byte, E_BADCHAR);
            res.n     = 2'd2;
            res.mode  = M_NUMBER;
          end else begin
            res.ev[0] = mk_ev(K_DONE, TT_NUMBER, CH_NUL, E_BADCHAR);
            res.ev[1] = mk_ev(K_ERR, TT_NULL, CH_NUL, E_BADCHAR);
            res.n     = 2'd2;
            res.mode  = M_ERROR;
          end
        end
        M_IDENT: begin
          if (is_ident_tail(char_byte)) begin
            res.ev[0] = mk_ev(K_TEXT, TT_IDENT, char_byte, E_BADCHAR);
            res.n     = 2'd1;
          end else begin
            res.ev[0] = mk_ev(K_DONE, TT_IDENT, CH_NUL, E_BADCHAR);
            res.ev[1] = ic.ev;
            res.n     = 2'd1 + {1'b0, ic.ev_v};
            res.mode  = ic.mode;
            res.bump  = ic.bump;
            if (ic.set_str) begin
              res.closer = ic.closer;
              res.esc    = 1'b0;
            end
          end
        end
        M_ERROR: begin
          // Drop everything until the end marker.
          res.mode = M_ERROR;
        end
        default: begin
          res.ev[0] = ic.ev;
          res.n     = {1'b0, ic.ev_v};
          res.mode  = ic.mode;
          res.bump  = ic.bump;
          if (ic.set_str) begin
            res.closer = ic.closer;
            res.esc    = 1'b0;
          end
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/ctt_outq.sv]
// Small event queue: takes up to three events a cycle, hands out one.
`default_nettype none
module ctt_outq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ctt_pkg::push_t              push,
  input  logic                        pop,
  output ctt_pkg::res_t               head,
  output logic [ctt_pkg::LVL_W-1:0]   level
);
  import ctt_pkg::*;

  res_t             mem [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [LVL_W-1:0] level_r, level_nxt;

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (2'(i) < push.n) begin
        mem[wr_ptr_r + PTR_W'(i)] <= push.rec[i];
      end
    end
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(push.n);
    rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
    level_nxt  = level_r + LVL_W'(push.n) - LVL_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  assign head  = mem[rd_ptr_r];
  assign level = level_r;

endmodule
`default_nettype wire
